FILE: hw/rtl/vsat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsat_pkg
// Shared types and constants of the volume summed-area table block.
// ----------------------------------------------------------------------------
package vsat_pkg;

  localparam int NCH      = 4;
  localparam int PIX_W    = 8;
  localparam int RUN_W    = 14;
  localparam int ROW_W    = 20;
  localparam int SUM_W    = 26;
  localparam int CFG_W    = 7;
  localparam int CIDX_W   = 2;
  localparam int DEF_SIZE = 64;
  localparam int DEF_MAX  = 64;

  localparam logic [CIDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CIDX_W-1:0] REG_SIZE_Z = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
    logic [PIX_W-1:0] alpha_in;
  } vsat_in_t;

  typedef struct packed {
    logic [SUM_W-1:0] red_sum;
    logic [SUM_W-1:0] green_sum;
    logic [SUM_W-1:0] blue_sum;
    logic [SUM_W-1:0] alpha_sum;
    logic             volume_done;
  } vsat_out_t;

endpackage

FILE: hw/rtl/vsat_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsat_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vsat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/volume_summed_area_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_summed_area_table
// Streaming 3D summed-area table over four-channel voxels in raster order.
//
// Voxels enter on in_valid/in_ready as one word each, x fastest, then y,
// then z. Each accepted word yields exactly one result word on
// out_valid/out_ready holding the four box sums from the origin to that
// voxel and a flag on the last voxel of the volume.
// Throughput: one voxel per cycle while the receiver keeps up, set by one
// read-modify-write per cycle on the plane store and the row store (one read and one write port each).
// An accepted voxel is registered in the read stage, and its result word is
// then registered in the output register; a stalled receiver holds it there.
// A stalled receiver holds the output register; one voxel more may then sit
// in the read stage, after which in_ready drops until the output drains.
// Reset clears the position to the origin and empties the pipeline; the
// sizes return to 64 (limited to the maximum). A cfg_ write sets a size and
// restarts the volume at the origin; write only while the block is idle.
// The stores need no clearing: every entry is written before its value is used.
// ----------------------------------------------------------------------------
module volume_summed_area_table
  import vsat_pkg::*;
#(
  parameter int MAX_X = DEF_MAX,
  parameter int MAX_Y = DEF_MAX,
  parameter int MAX_Z = DEF_MAX
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vsat_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output vsat_out_t         out_data,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int XW     = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int YW     = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int ZW     = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
  localparam int SXW    = $clog2(MAX_X + 1);
  localparam int SYW    = $clog2(MAX_Y + 1);
  localparam int SZW    = $clog2(MAX_Z + 1);
  localparam int PDEPTH = MAX_X * MAX_Y;
  localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int ROWWD  = NCH * ROW_W;
  localparam int PLWD   = NCH * SUM_W;
  localparam int SX_RST = (DEF_SIZE > MAX_X) ? MAX_X : DEF_SIZE;
  localparam int SY_RST = (DEF_SIZE > MAX_Y) ? MAX_Y : DEF_SIZE;
  localparam int SZ_RST = (DEF_SIZE > MAX_Z) ? MAX_Z : DEF_SIZE;

  // sizes and position
  logic [SXW-1:0] size_x_r;
  logic [SYW-1:0] size_y_r;
  logic [SZW-1:0] size_z_r;
  logic [SXW-1:0] cfg_sx;
  logic [SYW-1:0] cfg_sy;
  logic [SZW-1:0] cfg_sz;
  logic           cfg_restart;
  logic [XW-1:0]  pos_x_r, pos_x_nxt;
  logic [YW-1:0]  pos_y_r, pos_y_nxt;
  logic [ZW-1:0]  pos_z_r, pos_z_nxt;
  logic           last_x, last_y, last_z;
  logic           in_acc;
  logic [PAW-1:0] pl_raddr;

  // read stage
  logic                       s1_valid_r;
  logic                       s1_adv;
  logic                       s1_x0_r, s1_y0_r, s1_z0_r;
  logic                       s1_done_r;
  logic [NCH-1:0][PIX_W-1:0]  s1_pix_r;
  logic [XW-1:0]              s1_raddr_r;
  logic [PAW-1:0]             s1_paddr_r;
  logic                       s1_row_fwd_r, s1_pl_fwd_r;
  logic [ROWWD-1:0]           row_wlast_r;
  logic [PLWD-1:0]            pl_wlast_r;
  logic [ROWWD-1:0]           row_rdata;
  logic [PLWD-1:0]            pl_rdata;
  logic [ROWWD-1:0]           row_old;
  logic [PLWD-1:0]            pl_old;
  logic [NCH-1:0][RUN_W-1:0]  run_r, run_nxt;
  logic [NCH-1:0][ROW_W-1:0]  row_new;
  logic [NCH-1:0][SUM_W-1:0]  pl_new;
  logic [NCH-1:0][PIX_W-1:0]  pix;

  // output register
  logic      out_valid_r;
  vsat_out_t out_data_r;

  assign pix[0] = in_data.red_in;
  assign pix[1] = in_data.green_in;
  assign pix[2] = in_data.blue_in;
  assign pix[3] = in_data.alpha_in;

  // clamp: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (cfg_data == '0) begin
      cfg_sx = SXW'(1);
      cfg_sy = SYW'(1);
      cfg_sz = SZW'(1);
    end else begin
      cfg_sx = (int'(cfg_data) > MAX_X) ? SXW'(MAX_X) : SXW'(cfg_data);
      cfg_sy = (int'(cfg_data) > MAX_Y) ? SYW'(MAX_Y) : SYW'(cfg_data);
      cfg_sz = (int'(cfg_data) > MAX_Z) ? SZW'(MAX_Z) : SZW'(cfg_data);
    end
  end

  assign cfg_restart = cfg_we && (cfg_index == REG_SIZE_X || cfg_index == REG_SIZE_Y ||
                                  cfg_index == REG_SIZE_Z);

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  assign last_x = (int'(pos_x_r) + 1) >= int'(size_x_r);
  assign last_y = (int'(pos_y_r) + 1) >= int'(size_y_r);
  assign last_z = (int'(pos_z_r) + 1) >= int'(size_z_r);

  assign pl_raddr = PAW'(pos_y_r) * PAW'(MAX_X) + PAW'(pos_x_r);

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    pos_z_nxt = pos_z_r;
    if (!last_x) begin
      pos_x_nxt = pos_x_r + XW'(1);
    end else begin
      pos_x_nxt = '0;
      if (!last_y) begin
        pos_y_nxt = pos_y_r + YW'(1);
      end else begin
        pos_y_nxt = '0;
        pos_z_nxt = last_z ? '0 : pos_z_r + ZW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SXW'(SX_RST);
      size_y_r <= SYW'(SY_RST);
      size_z_r <= SZW'(SZ_RST);
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      pos_z_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIZE_X: size_x_r <= cfg_sx;
        REG_SIZE_Y: size_y_r <= cfg_sy;
        REG_SIZE_Z: size_z_r <= cfg_sz;
        default: ;
      endcase
      if (cfg_index == REG_SIZE_X || cfg_index == REG_SIZE_Y ||
          cfg_index == REG_SIZE_Z) begin
        pos_x_r <= '0;
        pos_y_r <= '0;
        pos_z_r <= '0;
      end
    end else if (in_acc) begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      pos_z_r <= pos_z_nxt;
    end
  end

  // stores
  vsat_ram #(.WIDTH(ROWWD), .DEPTH(MAX_X)) u_row_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_raddr_r),
    .wdata (row_new),
    .re    (in_acc),
    .raddr (pos_x_r),
    .rdata (row_rdata)
  );

  vsat_ram #(.WIDTH(PLWD), .DEPTH(PDEPTH)) u_plane_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_paddr_r),
    .wdata (pl_new),
    .re    (in_acc),
    .raddr (pl_raddr),
    .rdata (pl_rdata)
  );

  // read stage: capture voxel, flag same-entry writes in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x0_r      <= (pos_x_r == '0);
      s1_y0_r      <= (pos_y_r == '0);
      s1_z0_r      <= (pos_z_r == '0);
      s1_done_r    <= last_x && last_y && last_z;
      s1_pix_r     <= pix;
      s1_raddr_r   <= pos_x_r;
      s1_paddr_r   <= pl_raddr;
      s1_row_fwd_r <= s1_adv && (s1_raddr_r == pos_x_r);
      s1_pl_fwd_r  <= s1_adv && (s1_paddr_r == pl_raddr);
    end
    if (s1_adv) begin
      row_wlast_r <= row_new;
      pl_wlast_r  <= pl_new;
    end
  end

  assign row_old = s1_row_fwd_r ? row_wlast_r : row_rdata;
  assign pl_old  = s1_pl_fwd_r  ? pl_wlast_r  : pl_rdata;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      run_nxt[c] = (s1_x0_r ? RUN_W'(0) : run_r[c]) + RUN_W'(s1_pix_r[c]);
      row_new[c] = ROW_W'(run_nxt[c]) +
                   (s1_y0_r ? ROW_W'(0) : row_old[c*ROW_W +: ROW_W]);
      pl_new[c]  = SUM_W'(row_new[c]) +
                   (s1_z0_r ? SUM_W'(0) : pl_old[c*SUM_W +: SUM_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (cfg_restart) begin
      run_r <= '0;
    end else if (s1_adv) begin
      run_r <= run_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.red_sum     <= pl_new[0];
      out_data_r.green_sum   <= pl_new[1];
      out_data_r.blue_sum    <= pl_new[2];
      out_data_r.alpha_sum   <= pl_new[3];
      out_data_r.volume_done <= s1_done_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
